// File: hdl/mwf_pkg.sv
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared types, codes and constants of the wall-follower step unit.
// ----------------------------------------------------------------------------
package mwf_pkg;

   // Default side of the coordinate space (cells per row and per column).
   localparam int MAZE_DIM_DEFAULT = 16;

   localparam int COUNT_W   = 9;
   localparam int SIZE_W    = 5;
   localparam int SQUARE_W  = 2 * SIZE_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX         = 9'd511;
   localparam logic [SIZE_W-1:0]  BOARD_SIZE_RESET  = 5'd16;

   // Configuration register addresses.
   localparam int                CSR_ADDR_W          = 1;
   localparam logic [CSR_ADDR_W-1:0] REG_BOARD_SIZE_ADDR = 1'b0;

   // Headings in the board frame.
   localparam logic [1:0] HEADING_MINUS_X = 2'd0;
   localparam logic [1:0] HEADING_MINUS_Y = 2'd1;
   localparam logic [1:0] HEADING_PLUS_X  = 2'd2;
   localparam logic [1:0] HEADING_PLUS_Y  = 2'd3;

   // Mode codes as reported on the result channel.
   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_SCAN  = 2'd1;
   localparam logic [1:0] MODE_BACK  = 2'd2;
   localparam logic [1:0] MODE_SOLVE = 2'd3;

   typedef enum logic [3:0] {
      PHASE_READY = 4'b0001,
      PHASE_SCAN  = 4'b0010,
      PHASE_BACK  = 4'b0100,
      PHASE_SOLVE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      logic [1:0] heading;
      logic [1:0] mode;
      logic       record_valid;
      logic [3:0] record_x;
      logic [3:0] record_y;
      logic [3:0] record_walls;
   } rsp_type;

   function automatic logic [1:0] phase_to_mode(input phase_type phase);
      logic [1:0] mode;
      unique case (phase)
         PHASE_READY: mode = MODE_READY;
         PHASE_SCAN:  mode = MODE_SCAN;
         PHASE_BACK:  mode = MODE_BACK;
         PHASE_SOLVE: mode = MODE_SOLVE;
         default:     mode = MODE_READY;
      endcase
      return mode;
   endfunction

endpackage

// File: hdl/maze_wall_follower_step_unit.sv
// ----------------------------------------------------------------------------
// maze_wall_follower_step_unit
// Right-hand wall follower that scans a maze one cell per sensor beat.
// ----------------------------------------------------------------------------
// Each request beat carries one wall reading (left, front, right, relative to
// the robot) and produces exactly one response beat. The unit takes one
// request beat per clock cycle unless the response side stalls, and each beat
// passes through the request register and then the response register, with
// the turn, the move and the visited-map access done in a single pass between
// them. The visited map reads the cell about to be entered while it marks the
// cell being left, so back-to-back beats see an up-to-date map. After reset
// the map is swept clear, one cell per cycle; request beats are refused until
// the sweep is over, while configuration writes are taken at any time.
// Coordinates wrap at MAZE_DIM and are reported in four bits.
// ----------------------------------------------------------------------------
module maze_wall_follower_step_unit #(
   parameter int MAZE_DIM = mwf_pkg::MAZE_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] wall_left, [1] wall_front, [2] wall_right, [7:3] zero
   input  logic [7:0]                       req_tdata,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [3:0] cell_x, [7:4] cell_y, [9:8] heading, [11:10] mode,
   // [12] record_valid, [16:13] record_x, [20:17] record_y,
   // [24:21] record_walls, [31:25] zero
   output logic [31:0]                      rsp_tdata,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mwf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int CW = $clog2(MAZE_DIM);
   localparam int AW = $clog2(MAZE_DIM * MAZE_DIM);

   // Request register.
   logic                             in_valid_ff;
   logic [2:0]                       in_walls_ff;

   // Walker state.
   logic [CW-1:0]                    pos_x_ff;
   logic [CW-1:0]                    pos_y_ff;
   logic [1:0]                       dir_ff;
   mwf_pkg::phase_type               phase_ff;
   logic [mwf_pkg::COUNT_W-1:0]      count_ff;
   logic [mwf_pkg::SIZE_W-1:0]       board_size_ff;

   logic [CW-1:0]                    pos_x_in;
   logic [CW-1:0]                    pos_y_in;
   logic [1:0]                       dir_in;
   mwf_pkg::phase_type               phase_in;
   logic [mwf_pkg::COUNT_W-1:0]      count_in;

   // Response register.
   logic                             rsp_valid_ff;
   mwf_pkg::rsp_type                 rsp_ff;
   mwf_pkg::rsp_type                 rsp_in;

   logic                             step;
   logic                             cur_visited;
   logic                             clr_busy;
   logic [AW-1:0]                    cur_addr;
   logic [AW-1:0]                    next_addr;
   logic                             csr_write;

   // A beat leaves the request register whenever the response register is
   // empty or is being emptied in the same cycle.
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_busy && (!in_valid_ff || step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_walls_ff <= req_tdata[2:0];
      end
   end

   mwf_visit_map #(
      .MAZE_DIM (MAZE_DIM)
   ) u_visit_map (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .wr_addr (cur_addr),
      .rd_addr (next_addr),
      .visited (cur_visited),
      .busy    (clr_busy)
   );

   mwf_step_logic #(
      .MAZE_DIM (MAZE_DIM)
   ) u_step_logic (
      .wall_left  (in_walls_ff[0]),
      .wall_front (in_walls_ff[1]),
      .wall_right (in_walls_ff[2]),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .dir        (dir_ff),
      .phase      (phase_ff),
      .count      (count_ff),
      .visited    (cur_visited),
      .board_size (board_size_ff),
      .next_x     (pos_x_in),
      .next_y     (pos_y_in),
      .next_dir   (dir_in),
      .next_phase (phase_in),
      .next_count (count_in),
      .cur_addr   (cur_addr),
      .next_addr  (next_addr),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         dir_ff   <= mwf_pkg::HEADING_MINUS_Y;
         phase_ff <= mwf_pkg::PHASE_READY;
         count_ff <= '0;
      end else if (step) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         dir_ff   <= dir_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.record_walls, rsp_ff.record_y, rsp_ff.record_x,
                        rsp_ff.record_valid, rsp_ff.mode, rsp_ff.heading,
                        rsp_ff.cell_y, rsp_ff.cell_x};

   // Configuration: one register, board_size, at address zero. Writes to any
   // other address are dropped and read back as zero.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= mwf_pkg::BOARD_SIZE_RESET;
      end else if (csr_write && (csr_paddr == mwf_pkg::REG_BOARD_SIZE_ADDR)) begin
         board_size_ff <= csr_pwdata[mwf_pkg::SIZE_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr == mwf_pkg::REG_BOARD_SIZE_ADDR) begin
         csr_prdata = 32'(board_size_ff);
      end else begin
         csr_prdata = '0;
      end
   end

`ifndef SYNTHESIS
   // No beat may enter while the visited map is still being swept.
   assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_tready)
      else $error("request accepted during visited map sweep");

   // Every step moves the robot to a different cell.
   assert property (@(posedge clock) disable iff (reset)
      step |=> (pos_x_ff != $past(pos_x_ff)) || (pos_y_ff != $past(pos_y_ff)))
      else $error("step did not change the position");

   // A newly visited cell below the saturation limit bumps the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (step && !cur_visited && (count_ff != mwf_pkg::COUNT_MAX))
         |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("visit count not incremented for a new cell");

   // Once scanning has started the unit never falls back to the ready phase.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mwf_pkg::PHASE_READY) |=> (phase_ff != mwf_pkg::PHASE_READY))
      else $error("phase returned to ready");
`endif

endmodule

// File: hdl/mwf_visit_map.sv
// ----------------------------------------------------------------------------
// mwf_visit_map
// Visited-cell bitmap with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module mwf_visit_map #(
   parameter int MAZE_DIM = mwf_pkg::MAZE_DIM_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step,
   input  logic [$clog2(MAZE_DIM*MAZE_DIM)-1:0]    wr_addr,
   input  logic [$clog2(MAZE_DIM*MAZE_DIM)-1:0]    rd_addr,
   output logic                                    visited,
   output logic                                    busy
);

   localparam int DEPTH = MAZE_DIM * MAZE_DIM;
   localparam int AW    = $clog2(DEPTH);

   logic             map_mem [DEPTH];
   logic [AW-1:0]    clr_ptr_ff;
   logic [AW-1:0]    clr_ptr_in;
   logic             clr_busy_ff;
   logic             clr_busy_in;
   logic             visited_ff;

   always_comb begin
      clr_ptr_in  = clr_ptr_ff + 1'b1;
      clr_busy_in = clr_busy_ff && (clr_ptr_ff != AW'(DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_ptr_ff  <= clr_ptr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // The cell being left is marked while the cell being entered is read. The
   // two always differ, so the read never needs the value being written.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         map_mem[clr_ptr_ff] <= 1'b0;
      end else if (step) begin
         map_mem[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= 1'b0;
      end else if (step) begin
         visited_ff <= map_mem[rd_addr];
      end
   end

   assign visited = visited_ff;
   assign busy    = clr_busy_ff;

endmodule

// File: hdl/mwf_step_logic.sv
// ----------------------------------------------------------------------------
// mwf_step_logic
// Turn decision, move, wall record and phase update for one sensor beat.
// ----------------------------------------------------------------------------
module mwf_step_logic #(
   parameter int MAZE_DIM = mwf_pkg::MAZE_DIM_DEFAULT
) (
   input  logic                                    wall_left,
   input  logic                                    wall_front,
   input  logic                                    wall_right,
   input  logic [$clog2(MAZE_DIM)-1:0]             pos_x,
   input  logic [$clog2(MAZE_DIM)-1:0]             pos_y,
   input  logic [1:0]                              dir,
   input  mwf_pkg::phase_type                      phase,
   input  logic [mwf_pkg::COUNT_W-1:0]             count,
   input  logic                                    visited,
   input  logic [mwf_pkg::SIZE_W-1:0]              board_size,
   output logic [$clog2(MAZE_DIM)-1:0]             next_x,
   output logic [$clog2(MAZE_DIM)-1:0]             next_y,
   output logic [1:0]                              next_dir,
   output mwf_pkg::phase_type                      next_phase,
   output logic [mwf_pkg::COUNT_W-1:0]             next_count,
   output logic [$clog2(MAZE_DIM*MAZE_DIM)-1:0]    cur_addr,
   output logic [$clog2(MAZE_DIM*MAZE_DIM)-1:0]    next_addr,
   output mwf_pkg::rsp_type                        rsp
);

   localparam int CW = $clog2(MAZE_DIM);
   localparam int AW = $clog2(MAZE_DIM * MAZE_DIM);
   localparam int XW = (CW > 4) ? CW : 4;

   logic [1:0]                     dir_l;
   logic [1:0]                     dir_r;
   logic [3:0]                     walls;
   logic [mwf_pkg::SQUARE_W-1:0]   size_sq;
   logic [XW-1:0]                  cur_x_ext;
   logic [XW-1:0]                  cur_y_ext;
   logic [XW-1:0]                  nxt_x_ext;
   logic [XW-1:0]                  nxt_y_ext;

   always_comb begin
      dir_l = dir - 2'd1;
      dir_r = dir + 2'd1;

      walls        = '0;
      walls[dir_l] = wall_left;
      walls[dir]   = wall_front;
      walls[dir_r] = wall_right;

      // Right-hand rule: right, else straight, else left, else about turn.
      if (!wall_right) begin
         next_dir = dir_r;
      end else if (!wall_front) begin
         next_dir = dir;
      end else if (!wall_left) begin
         next_dir = dir_l;
      end else begin
         next_dir = dir + 2'd2;
      end

      next_x = pos_x;
      next_y = pos_y;
      case (next_dir)
         mwf_pkg::HEADING_MINUS_X: begin
            next_x = (pos_x == '0) ? CW'(MAZE_DIM - 1) : pos_x - 1'b1;
         end
         mwf_pkg::HEADING_MINUS_Y: begin
            next_y = (pos_y == '0) ? CW'(MAZE_DIM - 1) : pos_y - 1'b1;
         end
         mwf_pkg::HEADING_PLUS_X: begin
            next_x = (pos_x == CW'(MAZE_DIM - 1)) ? '0 : pos_x + 1'b1;
         end
         default: begin
            next_y = (pos_y == CW'(MAZE_DIM - 1)) ? '0 : pos_y + 1'b1;
         end
      endcase

      cur_addr  = AW'(pos_y) * AW'(MAZE_DIM) + AW'(pos_x);
      next_addr = AW'(next_y) * AW'(MAZE_DIM) + AW'(next_x);

      if (!visited && (count != mwf_pkg::COUNT_MAX)) begin
         next_count = count + 1'b1;
      end else begin
         next_count = count;
      end

      size_sq = mwf_pkg::SQUARE_W'(board_size) * mwf_pkg::SQUARE_W'(board_size);

      next_phase = phase;
      unique case (phase)
         mwf_pkg::PHASE_READY: next_phase = mwf_pkg::PHASE_SCAN;
         mwf_pkg::PHASE_SCAN: begin
            if (mwf_pkg::SQUARE_W'(next_count) >= size_sq) begin
               next_phase = mwf_pkg::PHASE_BACK;
            end
         end
         mwf_pkg::PHASE_BACK: begin
            if ((next_x == '0) && (next_y == '0)) begin
               next_phase = mwf_pkg::PHASE_SOLVE;
            end
         end
         mwf_pkg::PHASE_SOLVE: next_phase = phase;
         default:              next_phase = phase;
      endcase

      cur_x_ext = XW'(pos_x);
      cur_y_ext = XW'(pos_y);
      nxt_x_ext = XW'(next_x);
      nxt_y_ext = XW'(next_y);

      rsp.cell_x       = nxt_x_ext[3:0];
      rsp.cell_y       = nxt_y_ext[3:0];
      rsp.heading      = next_dir;
      rsp.mode         = mwf_pkg::phase_to_mode(next_phase);
      rsp.record_valid = !visited;
      rsp.record_x     = visited ? 4'd0 : cur_x_ext[3:0];
      rsp.record_y     = visited ? 4'd0 : cur_y_ext[3:0];
      rsp.record_walls = visited ? 4'd0 : walls;
   end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wall-follower step unit.
// ----------------------------------------------------------------------------
// Sensor beats go in through the request stream. Each response beat is
// compared field by field with a model of the robot that the bench keeps in
// step with every accepted request. The run passes through every phase of the
// scan. It starts with hand-picked readings, then random walks on boards that
// never finish scanning. A full serpentine sweep then completes the scan
// exactly at the last new cell. A steered walk brings the robot back to the
// origin, and random walking continues in the final phase. The board size
// register is written with its extremes and read back each time.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Relative turns, as the difference between the new and the old heading.
   localparam logic [1:0] TURN_NONE  = 2'd0;
   localparam logic [1:0] TURN_RIGHT = 2'd1;
   localparam logic [1:0] TURN_BACK  = 2'd2;
   localparam logic [1:0] TURN_LEFT  = 2'd3;

   localparam int IDLE_LIMIT = 4000;

   // Packed so that the left wall lands in bit 0 of the request data.
   typedef struct packed {
      logic wall_right;
      logic wall_front;
      logic wall_left;
   } sensor_type;

   typedef enum {
      READY_ALWAYS,
      READY_PERIODIC,
      READY_RANDOM,
      READY_SPARSE
   } stall_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [mwf_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Model of the robot.
   logic        cell_seen [0:255];
   logic [8:0]  cells_counted;
   logic [3:0]  robot_x;
   logic [3:0]  robot_y;
   logic [1:0]  robot_heading;
   logic [1:0]  robot_mode;
   logic [4:0]  board_side;

   mwf_pkg::rsp_type expected_steps [$];
   int          errors = 0;
   int          beats_sent = 0;
   int          records_seen = 0;
   int          csr_writes = 0;
   int          burst_left = 0;

   maze_wall_follower_step_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One step of the robot: record the cell if it is new, turn, move and
   // advance the phase. Returns the response beat this reading must produce.
   task automatic advance_robot(input sensor_type s, output mwf_pkg::rsp_type step);
      logic [7:0] cell_idx;
      cell_idx = {robot_y, robot_x};
      step = '0;
      if (!cell_seen[cell_idx]) begin
         cell_seen[cell_idx] = 1'b1;
         if (cells_counted != mwf_pkg::COUNT_MAX) cells_counted++;
         step.record_valid = 1'b1;
         step.record_x = robot_x;
         step.record_y = robot_y;
         // Board-frame walls: the bit behind the robot stays clear.
         step.record_walls[robot_heading - 2'd1] = s.wall_left;
         step.record_walls[robot_heading]        = s.wall_front;
         step.record_walls[robot_heading + 2'd1] = s.wall_right;
      end
      // Keep a hand on the right wall.
      if (!s.wall_right)      robot_heading = robot_heading + TURN_RIGHT;
      else if (!s.wall_front) robot_heading = robot_heading + TURN_NONE;
      else if (!s.wall_left)  robot_heading = robot_heading + TURN_LEFT;
      else                    robot_heading = robot_heading + TURN_BACK;
      // Four-bit coordinates wrap at the default board dimension of 16.
      case (robot_heading)
         mwf_pkg::HEADING_MINUS_X: robot_x = robot_x - 4'd1;
         mwf_pkg::HEADING_MINUS_Y: robot_y = robot_y - 4'd1;
         mwf_pkg::HEADING_PLUS_X:  robot_x = robot_x + 4'd1;
         default:                  robot_y = robot_y + 4'd1;
      endcase
      case (robot_mode)
         mwf_pkg::MODE_READY: robot_mode = mwf_pkg::MODE_SCAN;
         mwf_pkg::MODE_SCAN: begin
            if (int'(cells_counted) >= int'(board_side) * int'(board_side))
               robot_mode = mwf_pkg::MODE_BACK;
         end
         mwf_pkg::MODE_BACK: begin
            if (robot_x == 4'd0 && robot_y == 4'd0) robot_mode = mwf_pkg::MODE_SOLVE;
         end
         default: ;
      endcase
      step.cell_x  = robot_x;
      step.cell_y  = robot_y;
      step.heading = robot_heading;
      step.mode    = robot_mode;
   endtask

   // Sends one sensor beat. The sender works in bursts with random gaps in
   // between; the valid is only lowered at the start of a gap.
   task automatic send_reading(input sensor_type s);
      int gap;
      mwf_pkg::rsp_type step;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, s};
      do @(posedge clock); while (!req_tready);
      advance_robot(s, step);
      expected_steps.push_back(step);
      beats_sent++;
   endtask

   // Picks walls that make the robot take the wanted heading. Walls that do
   // not decide the turn are left random.
   task automatic steer_to(input logic [1:0] wanted);
      sensor_type s;
      s = sensor_type'($urandom_range(0, 7));
      case (wanted - robot_heading)
         TURN_RIGHT: s.wall_right = 1'b0;
         TURN_NONE: begin
            s.wall_right = 1'b1;
            s.wall_front = 1'b0;
         end
         TURN_LEFT: begin
            s.wall_right = 1'b1;
            s.wall_front = 1'b1;
            s.wall_left  = 1'b0;
         end
         default: s = 3'b111;
      endcase
      send_reading(s);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_reading(sensor_type'($urandom_range(0, 7)));
   endtask

   // Waits until the unit has answered everything, with a little margin.
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= mwf_pkg::REG_BOARD_SIZE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Writes the board side with junk in the unused upper bits, then reads it
   // back.
   task automatic set_board_side(input logic [4:0] side);
      logic [31:0] rdata;
      csr_access(1'b1, ($urandom() & ~32'h1f) | side, rdata);
      board_side = side;
      csr_writes++;
      csr_access(1'b0, '0, rdata);
      if (rdata !== {27'b0, board_side}) begin
         $display("%0t: board_size read back expected %0d, got %0d",
                  $time, board_side, rdata);
         errors++;
      end
   endtask

   // Every turn kind and all eight wall patterns from the reset position,
   // a turn-around onto a cell already recorded, and wrapping on both axes.
   task automatic test_first_steps();
      for (int w = 0; w < 8; w++) send_reading(sensor_type'(w));
      send_reading(3'b111);
      send_reading(3'b111);
      while (robot_x != 4'd0) steer_to(mwf_pkg::HEADING_MINUS_X);
      steer_to(mwf_pkg::HEADING_MINUS_X);
      steer_to(mwf_pkg::HEADING_MINUS_X);
      while (robot_y != 4'd0) steer_to(mwf_pkg::HEADING_MINUS_Y);
      steer_to(mwf_pkg::HEADING_MINUS_Y);
      steer_to(mwf_pkg::HEADING_PLUS_Y);
      settle();
   endtask

   // Random walking on boards too large to ever finish the scan.
   task automatic test_scan_wide_board();
      set_board_side(5'd31);
      send_random(500);
      settle();
      set_board_side(5'd17);
      send_random(100);
      settle();
   endtask

   // A serpentine over all 256 cells. With a side of 16, the scan completes
   // on exactly the step that records the last new cell.
   task automatic test_full_sweep();
      set_board_side(5'd16);
      for (int row = 0; row < 16; row++) begin
         repeat (15) steer_to(mwf_pkg::HEADING_MINUS_X);
         steer_to(mwf_pkg::HEADING_MINUS_Y);
      end
      settle();
   endtask

   // Heads for the origin by the short way round. If the robot is already
   // there, it steps off and back again, since only arriving counts.
   task automatic test_return_home();
      while (robot_mode != mwf_pkg::MODE_SOLVE) begin
         if (robot_x != 4'd0)
            steer_to(robot_x <= 4'd8 ? mwf_pkg::HEADING_MINUS_X
                                     : mwf_pkg::HEADING_PLUS_X);
         else if (robot_y != 4'd0)
            steer_to(robot_y <= 4'd8 ? mwf_pkg::HEADING_MINUS_Y
                                     : mwf_pkg::HEADING_PLUS_Y);
         else
            steer_to(mwf_pkg::HEADING_PLUS_X);
      end
      settle();
   endtask

   // The final phase holds whatever the board size says, while stepping goes on.
   task automatic test_solve_hold();
      set_board_side(5'd0);
      send_random(300);
      settle();
      set_board_side(5'd1);
      send_random(200);
      settle();
      set_board_side(5'($urandom_range(2, 30)));
      send_random(100);
      settle();
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Response side: checks each accepted beat against the oldest expectation
   // and stalls the response stream in randomly chosen styles.
   always @(posedge clock) begin : response_check
      mwf_pkg::rsp_type want;
      mwf_pkg::rsp_type got;
      static int cycle_no = 0;
      static stall_style_type stall_style = READY_ALWAYS;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cell_x       = rsp_tdata[3:0];
         got.cell_y       = rsp_tdata[7:4];
         got.heading      = rsp_tdata[9:8];
         got.mode         = rsp_tdata[11:10];
         got.record_valid = rsp_tdata[12];
         got.record_x     = rsp_tdata[16:13];
         got.record_y     = rsp_tdata[20:17];
         got.record_walls = rsp_tdata[24:21];
         if (expected_steps.size() == 0) begin
            $display("%0t: response beat expected none, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = expected_steps.pop_front();
            if (want.record_valid) records_seen++;
            check_field("cell_x", want.cell_x, got.cell_x);
            check_field("cell_y", want.cell_y, got.cell_y);
            check_field("heading", want.heading, got.heading);
            check_field("mode", want.mode, got.mode);
            check_field("record_valid", want.record_valid, got.record_valid);
            check_field("record_x", want.record_x, got.record_x);
            check_field("record_y", want.record_y, got.record_y);
            check_field("record_walls", want.record_walls, got.record_walls);
         end
      end
      if (cycle_no % 128 == 0) stall_style = stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_PERIODIC: rsp_tready <= (cycle_no % 5) < 3;
         READY_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
         default:        rsp_tready <= (cycle_no % 16) >= 12;
      endcase
      cycle_no++;
   end

   // Ends the run if nothing moves for too long. The limit covers the clearing
   // sweep of the visited map after reset.
   always @(posedge clock) begin : watchdog
      static int idle_cycles = 0;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("maze_wall_follower_step_unit: mismatch");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 256; i++) cell_seen[i] = 1'b0;
      cells_counted = '0;
      robot_x = '0;
      robot_y = '0;
      robot_heading = mwf_pkg::HEADING_MINUS_Y;
      robot_mode = mwf_pkg::MODE_READY;
      board_side = mwf_pkg::BOARD_SIZE_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_first_steps();
      test_scan_wide_board();
      test_full_sweep();
      test_return_home();
      test_solve_hold();

      $display("Covered %0d sensor beats, %0d wall records, %0d board size writes;",
               beats_sent, records_seen, csr_writes);
      $display("ended in mode %0d at cell %0d,%0d with %0d cells counted.",
               robot_mode, robot_x, robot_y, cells_counted);
      if (errors == 0)
         $display("maze_wall_follower_step_unit: match");
      else
         $display("maze_wall_follower_step_unit: mismatch");
      $finish;
   end

endmodule
